// ===== sv/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt-compensated compass package
// Shared widths, angle constants, the arctangent table and the rotation bus.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int DW            = 30;   // CORDIC vector width
	localparam int ZW            = 27;   // angle width, degrees in Q.16
	localparam int AVW           = 32;   // filter average width, Q16.16
	localparam int TAB_LEN       = 24;
	localparam int DEFAULT_STEPS = 16;

	localparam logic signed [ZW-1:0] DEG180 = 27'sd11796480;
	localparam logic signed [ZW-1:0] DEG360 = 27'sd23592960;
	localparam logic signed [30:0]   INV_GAIN = 31'sd652032874;
	localparam logic signed [ZW-1:0] ANGLE_LIMIT = 27'sd23040;
	localparam logic signed [ZW-1:0] HEADING_SPAN = 27'sd46080;
	localparam logic signed [ZW-1:0] ROUND_HALF = 27'sd256;

	localparam logic [1:0] REG_GAIN  = 2'd0;
	localparam logic [1:0] REG_OFF_X = 2'd1;
	localparam logic [1:0] REG_OFF_Y = 2'd2;
	localparam logic [1:0] REG_OFF_Z = 2'd3;

	localparam logic [15:0] GAIN_RESET = 16'd13107;

	typedef logic signed [DW-1:0] dat_t;
	typedef logic signed [ZW-1:0] ang_t;

	typedef struct packed {
		logic vld;
		dat_t x;
		dat_t y;
		dat_t p;
		dat_t q;
		ang_t z;
	} rot_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FMUL, ST_FUPD, ST_LOAD, ST_RUN, ST_UNS, ST_NEXT, ST_OUT
	} state_t;

	typedef enum logic [1:0] { PASS_ROLL, PASS_PITCH, PASS_HEAD } pass_t;

	// round(atan(2^-i) * 180/pi * 65536)
	function automatic ang_t atan_entry(input int idx);
		ang_t r;
		case (idx)
			0: r = 27'sd2949120;
			1: r = 27'sd1740967;
			2: r = 27'sd919879;
			3: r = 27'sd466945;
			4: r = 27'sd234379;
			5: r = 27'sd117304;
			6: r = 27'sd58666;
			7: r = 27'sd29335;
			8: r = 27'sd14668;
			9: r = 27'sd7334;
			10: r = 27'sd3667;
			11: r = 27'sd1833;
			12: r = 27'sd917;
			13: r = 27'sd458;
			14: r = 27'sd229;
			15: r = 27'sd115;
			16: r = 27'sd57;
			17: r = 27'sd29;
			18: r = 27'sd14;
			19: r = 27'sd7;
			20: r = 27'sd4;
			21: r = 27'sd2;
			22: r = 27'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/tcc_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC micro-rotation cell
// One vectoring step with a fixed shift; the carried vector follows along.
// ----------------------------------------------------------------------------
module tcc_cell #(
	parameter int SHIFT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tcc_pkg::rot_t din,
	output tcc_pkg::rot_t dout
);
	import tcc_pkg::*;

	localparam ang_t ATAN = atan_entry(SHIFT);

	rot_t nxt;

	always_comb begin
		nxt     = din;
		if (din.y >= 0) begin
			nxt.x = din.x + (din.y >>> SHIFT);
			nxt.y = din.y - (din.x >>> SHIFT);
			nxt.p = din.p + (din.q >>> SHIFT);
			nxt.q = din.q - (din.p >>> SHIFT);
			nxt.z = din.z + ATAN;
		end else begin
			nxt.x = din.x - (din.y >>> SHIFT);
			nxt.y = din.y + (din.x >>> SHIFT);
			nxt.p = din.p - (din.q >>> SHIFT);
			nxt.q = din.q + (din.p >>> SHIFT);
			nxt.z = din.z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout <= nxt;
		end
	end

endmodule

// ===== sv/tcc_chain.sv =====
// ----------------------------------------------------------------------------
// CORDIC cell row
// A row of registered micro-rotation cells, one shift per cell.
// ----------------------------------------------------------------------------
module tcc_chain #(
	parameter int STEPS = tcc_pkg::DEFAULT_STEPS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tcc_pkg::rot_t din,
	output tcc_pkg::rot_t dout
);
	import tcc_pkg::*;

	rot_t link [STEPS+1];

	assign link[0] = din;

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		tcc_cell #(.SHIFT(i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (link[i]),
			.dout  (link[i+1])
		);
	end

	assign dout = link[STEPS];

endmodule

// ===== sv/tilt_compensated_compass.sv =====
// ----------------------------------------------------------------------------
// Tilt-compensated compass
// Filters six sensor axes and derives roll, pitch and heading by CORDIC.
// ----------------------------------------------------------------------------
// Input channel: one transaction carries a six-axis sample. in_ready is high
// only while the block is idle, so one sample is processed at a time.
// Output channel: one transaction per sample with roll, pitch and heading
// in 1/128 degree. The result sits in an output register; a new sample is
// taken while it waits, and the block only stalls at its final step if the
// previous result has not yet been taken.
// Sequence: filtering with one shared multiplier, a multiply and an update
// step per axis, then three CORDIC passes (roll, pitch, heading) through
// the cell row and the shared inverse-gain multiplier, then an output
// step. A new sample is taken only in the idle state, once the previous
// one has reached the output register.
// Configuration writes (cfg_we, cfg_addr, cfg_data) take effect at once. The
// user must make them only while the block is idle; it does not enforce this.
// Reset clears the averages, sets the gain to 13107 and the offsets to zero,
// and clears the output valid flag.
// ----------------------------------------------------------------------------
module tilt_compensated_compass #(
	parameter int CORDIC_STEPS = tcc_pkg::DEFAULT_STEPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] mag_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic        [15:0] heading_angle,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [15:0]        cfg_data
);
	import tcc_pkg::*;

	state_t state_q, state_d;
	pass_t  pass_q;

	logic [15:0]              gain_q;
	logic signed [15:0]       offx_q, offy_q, offz_q;
	logic signed [AVW-1:0]    avg_q [6];
	logic signed [15:0]       smp_q [6];
	logic [2:0]               fcnt_q;
	logic signed [49:0]       fprod_q;
	logic signed [AVW:0]      fd;
	logic signed [AVW+1:0]    fsh;
	logic signed [AVW-1:0]    avg_new;

	dat_t opx_q, opy_q, opp_q, opq_q;
	logic zero_q;
	dat_t cx_q, cp_q, cq_q;
	ang_t cz_q;
	logic [1:0] ucnt_q;
	logic signed [60:0] uprod_q;
	dat_t usel;
	dat_t rmag_q, rp_q, rq_q;
	dat_t by_q;
	ang_t roll_q, pitch_q, psi_q;

	dat_t gx, bx;
	ang_t r_ang;
	dat_t r_mag, r_p, r_q;

	rot_t chain_in, chain_out;

	ang_t roll_r, pitch_r, psi_w, head_r, head_w;

	logic out_valid_q;
	logic signed [15:0] roll_out_q, pitch_out_q;
	logic [15:0] head_out_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			offx_q <= '0;
			offy_q <= '0;
			offz_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_GAIN:  gain_q <= cfg_data;
				REG_OFF_X: offx_q <= cfg_data;
				REG_OFF_Y: offy_q <= cfg_data;
				REG_OFF_Z: offz_q <= cfg_data;
				default:   gain_q <= gain_q;
			endcase
		end
	end

	// ---------------- filter arithmetic ----------------
	// The averages rotate through a ring; slot zero is always the one updated, and its new value goes to slot five.
	assign fd      = (AVW+1)'(avg_q[0]) - ((AVW+1)'(smp_q[0]) <<< 16);
	assign fsh     = (AVW+2)'(fprod_q >>> 16);
	assign avg_new = AVW'((AVW+2)'(avg_q[0]) - fsh);

	assign gx = DW'(avg_q[0] >>> 8);
	assign bx = DW'(avg_q[3] >>> 8) - (DW'(offx_q) <<< 8);

	// ---------------- CORDIC launch ----------------
	// A vector in the left half-plane is negated and starts at +/-180 degrees.
	always_comb begin
		chain_in     = '0;
		chain_in.vld = (state_q == ST_LOAD);
		if (opx_q < 0) begin
			chain_in.x = -opx_q;
			chain_in.y = -opy_q;
			chain_in.p = -opp_q;
			chain_in.q = -opq_q;
			chain_in.z = (opy_q >= 0) ? DEG180 : -DEG180;
		end else begin
			chain_in.x = opx_q;
			chain_in.y = opy_q;
			chain_in.p = opp_q;
			chain_in.q = opq_q;
		end
	end

	tcc_chain #(.STEPS(CORDIC_STEPS)) u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (chain_in),
		.dout  (chain_out)
	);

	always_comb begin
		case (ucnt_q)
			2'd0:    usel = cx_q;
			2'd1:    usel = cp_q;
			default: usel = cq_q;
		endcase
	end

	// A zero vector gives angle zero and passes the carried vector unchanged.
	assign r_ang = zero_q ? '0 : cz_q;
	assign r_mag = zero_q ? '0 : rmag_q;
	assign r_p   = zero_q ? opp_q : rp_q;
	assign r_q   = zero_q ? opq_q : rq_q;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_FMUL;
			end
			ST_FMUL: state_d = ST_FUPD;
			ST_FUPD: state_d = (fcnt_q == 3'd5) ? ST_LOAD : ST_FMUL;
			ST_LOAD: state_d = ST_RUN;
			ST_RUN:  if (chain_out.vld) state_d = ST_UNS;
			ST_UNS:  if (ucnt_q == 2'd3) state_d = ST_NEXT;
			ST_NEXT: state_d = (pass_q == PASS_HEAD) ? ST_OUT : ST_LOAD;
			ST_OUT:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) avg_q[i] <= '0;
			fcnt_q <= '0;
			ucnt_q <= '0;
			pass_q <= PASS_ROLL;
		end else begin
			case (state_q)
				ST_IDLE: begin
					fcnt_q <= '0;
					pass_q <= PASS_ROLL;
				end
				ST_FUPD: begin
					for (int i = 0; i < 5; i++) avg_q[i] <= avg_q[i+1];
					avg_q[5] <= avg_new;
					fcnt_q   <= fcnt_q + 3'd1;
				end
				ST_LOAD: ucnt_q <= '0;
				ST_UNS:  ucnt_q <= ucnt_q + 2'd1;
				ST_NEXT: begin
					case (pass_q)
						PASS_ROLL:  pass_q <= PASS_PITCH;
						PASS_PITCH: pass_q <= PASS_HEAD;
						default:    pass_q <= PASS_HEAD;
					endcase
				end
				default: fcnt_q <= fcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				smp_q[0] <= accel_x;
				smp_q[1] <= accel_y;
				smp_q[2] <= accel_z;
				smp_q[3] <= mag_x;
				smp_q[4] <= mag_y;
				smp_q[5] <= mag_z;
			end
			ST_FMUL: fprod_q <= fd * $signed({1'b0, gain_q});
			ST_FUPD: begin
				for (int i = 0; i < 5; i++) smp_q[i] <= smp_q[i+1];
				smp_q[5] <= smp_q[0];
				if (fcnt_q == 3'd5) begin
					// Ring is back in order once the last axis is written.
					opx_q <= DW'(avg_q[3] >>> 8);
					opy_q <= DW'(avg_q[2] >>> 8);
					opp_q <= DW'(avg_new >>> 8) - (DW'(offz_q) <<< 8);
					opq_q <= DW'(avg_q[5] >>> 8) - (DW'(offy_q) <<< 8);
				end
			end
			ST_LOAD: zero_q <= (opx_q == '0) && (opy_q == '0);
			ST_RUN: begin
				cx_q <= chain_out.x;
				cp_q <= chain_out.p;
				cq_q <= chain_out.q;
				cz_q <= chain_out.z;
			end
			ST_UNS: begin
				uprod_q <= usel * INV_GAIN;
				case (ucnt_q)
					2'd1:    rmag_q <= uprod_q[59:30];
					2'd2:    rp_q   <= uprod_q[59:30];
					2'd3:    rq_q   <= uprod_q[59:30];
					default: rmag_q <= rmag_q;
				endcase
			end
			ST_NEXT: begin
				case (pass_q)
					PASS_ROLL: begin
						roll_q <= r_ang;
						opx_q  <= r_mag;
						opy_q  <= -gx;
						opp_q  <= bx;
						opq_q  <= r_p;
						by_q   <= r_q;
					end
					PASS_PITCH: begin
						pitch_q <= r_ang;
						opx_q   <= r_p;
						opy_q   <= -by_q;
						opp_q   <= '0;
						opq_q   <= '0;
					end
					default: psi_q <= r_ang;
				endcase
			end
			default: cz_q <= cz_q;
		endcase
	end

	// ---------------- output formatting ----------------
	always_comb begin
		roll_r  = (roll_q + ROUND_HALF) >>> 9;
		pitch_r = (pitch_q + ROUND_HALF) >>> 9;
		if (roll_r > ANGLE_LIMIT) roll_r = ANGLE_LIMIT;
		else if (roll_r < -ANGLE_LIMIT) roll_r = -ANGLE_LIMIT;
		if (pitch_r > ANGLE_LIMIT) pitch_r = ANGLE_LIMIT;
		else if (pitch_r < -ANGLE_LIMIT) pitch_r = -ANGLE_LIMIT;
		psi_w  = (psi_q < 0) ? psi_q + DEG360 : psi_q;
		head_r = (psi_w + ROUND_HALF) >>> 9;
		head_w = (head_r >= HEADING_SPAN) ? head_r - HEADING_SPAN : head_r;
		if (head_w < 0) head_w = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			roll_out_q  <= 16'(roll_r);
			pitch_out_q <= 16'(pitch_r);
			head_out_q  <= 16'(head_w);
		end
	end

	assign out_valid     = out_valid_q;
	assign roll_angle    = roll_out_q;
	assign pitch_angle   = pitch_out_q;
	assign heading_angle = head_out_q;

endmodule
